// ----- hdl/glc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glc_pkg: shared types and constants of the gesture code lock
// command, event and mode codes, word structs, reset values, digit helper
// ----------------------------------------------------------------------------
package glc_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int POS_W       = 2;
    localparam int DIGIT_W     = 4;
    localparam int TIMER_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ADMIN_HOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CODE  = 2'd2;

    localparam logic [TIMER_W-1:0]    ADMIN_HOLD_RST    = 16'd2000;
    localparam logic [TIMER_W-1:0]    CHANGE_WINDOW_RST = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] DEFAULT_CODE_RST  = 16'h1234;
    localparam logic [TIMER_W-1:0]    TIMER_MAX         = 16'hFFFF;
    localparam logic [DIGIT_W-1:0]    DIGIT_MAX         = 4'd9;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CLICK  = 2'd1,
        CMD_DOUBLE = 2'd2,
        CMD_LONG   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_ADVANCED  = 4'd1,
        EV_COMMITTED = 4'd2,
        EV_UNLOCKED  = 4'd3,
        EV_DENIED    = 4'd4,
        EV_SAVED     = 4'd5,
        EV_CLEARED   = 4'd6,
        EV_CANCELLED = 4'd7,
        EV_EXPIRED   = 4'd8,
        EV_RESET     = 4'd9
    } event_t;

    typedef enum logic [1:0] {
        MODE_ENTER  = 2'd0,
        MODE_PROMPT = 2'd1,
        MODE_CHANGE = 2'd2
    } mode_t;

    typedef logic [CODE_LENGTH-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        cmd_t cmd;
        logic admin_low;
    } item_t;

    typedef struct packed {
        event_t              event_res;
        mode_t               lock_mode;
        logic [POS_W-1:0]    digit_position;
        logic [DIGIT_W-1:0]  digit_value;
    } result_t;

    typedef struct packed {
        logic [TIMER_W-1:0]    admin_hold_ms;
        logic [TIMER_W-1:0]    change_window_ms;
        logic [CFG_DATA_W-1:0] default_code;
    } cfg_t;

    // first digit in the top nibble, positions past the fourth read zero
    function automatic digits_t code_digits(input logic [CFG_DATA_W-1:0] code);
        digits_t d;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            d[i] = (i < 4) ? code[CFG_DATA_W-1-4*(i%4) -: DIGIT_W] : '0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/glc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glc_in_if: gesture word channel
// valid/ready handshake carrying one decoded gesture or tick
// ----------------------------------------------------------------------------
interface glc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       admin_low;

    modport source (output valid, output cmd, output admin_low, input ready);
    modport sink   (input valid, input cmd, input admin_low, output ready);
endinterface
`default_nettype wire

// ----- hdl/glc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glc_out_if: result word channel
// valid/ready handshake carrying event, mode and digit being entered
// ----------------------------------------------------------------------------
interface glc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [1:0] lock_mode;
    logic [1:0] digit_position;
    logic [3:0] digit_value;

    modport source (output valid, output event_res, output lock_mode,
                    output digit_position, output digit_value, input ready);
    modport sink   (input valid, input event_res, input lock_mode,
                    input digit_position, input digit_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/glc_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glc_cfg: configuration registers
// hold time, change window and factory code, written by index
// ----------------------------------------------------------------------------
module glc_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [glc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [glc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output glc_pkg::cfg_t                       cfg
);
    import glc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ADMIN_HOLD:    cfg_next.admin_hold_ms    = cfg_wdata;
                CFG_CHANGE_WINDOW: cfg_next.change_window_ms = cfg_wdata;
                CFG_DEFAULT_CODE:  cfg_next.default_code     = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.admin_hold_ms    <= ADMIN_HOLD_RST;
            cfg_reg.change_window_ms <= CHANGE_WINDOW_RST;
            cfg_reg.default_code     <= DEFAULT_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

// ----- hdl/glc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glc_core: lock state and next-state logic
// one word per fire: updates state and returns the result of that word
// ----------------------------------------------------------------------------
module glc_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  glc_pkg::item_t   item,
    input  glc_pkg::cfg_t    cfg,
    output glc_pkg::result_t res
);
    import glc_pkg::*;

    mode_t                mode_reg, mode_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [DIGIT_W-1:0]   value_reg, value_next;
    digits_t              entry_reg, entry_next;
    digits_t              stored_reg, stored_next;
    logic [TIMER_W-1:0]   window_reg, window_next;
    logic                 was_low_reg, was_low_next;
    logic [TIMER_W-1:0]   held_reg, held_next;
    logic                 done_reg, done_next;
    event_t               ev;
    logic [POS_W-1:0]     wpos;
    mode_t                commit_mode;

    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        value_next   = value_reg;
        entry_next   = entry_reg;
        stored_next  = stored_reg;
        window_next  = window_reg;
        was_low_next = was_low_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        ev           = EV_NONE;
        wpos         = (mode_reg == MODE_PROMPT) ? '0 : pos_reg;
        commit_mode  = (mode_reg == MODE_PROMPT) ? MODE_CHANGE : mode_reg;

        case (item.cmd)
            CMD_TICK:
            begin
                // admin button timing first
                if (item.admin_low)
                begin
                    if (!was_low_reg)
                    begin
                        held_next = '0;
                        done_next = 1'b0;
                    end
                    else if (held_reg != TIMER_MAX)
                    begin
                        held_next = held_reg + 1'b1;
                    end
                    if (!done_next && held_next >= cfg.admin_hold_ms)
                    begin
                        done_next   = 1'b1;
                        stored_next = code_digits(cfg.default_code);
                        mode_next   = MODE_ENTER;
                        pos_next    = '0;
                        value_next  = '0;
                        window_next = '0;
                        ev          = EV_RESET;
                    end
                end
                was_low_next = item.admin_low;
                // then prompt expiry
                if (mode_next == MODE_PROMPT)
                begin
                    if (window_next != '0)
                    begin
                        window_next = window_next - 1'b1;
                    end
                    if (window_next == '0)
                    begin
                        mode_next = MODE_ENTER;
                        ev        = EV_EXPIRED;
                    end
                end
            end
            CMD_CLICK:
            begin
                if (mode_reg == MODE_PROMPT)
                begin
                    mode_next  = MODE_CHANGE;
                    pos_next   = '0;
                    value_next = DIGIT_W'(1);
                end
                else
                begin
                    value_next = (value_reg == DIGIT_MAX) ? '0 : value_reg + 1'b1;
                end
                ev = EV_ADVANCED;
            end
            CMD_DOUBLE:
            begin
                pos_next   = '0;
                value_next = '0;
                if (mode_reg == MODE_PROMPT)
                begin
                    mode_next = MODE_ENTER;
                    ev        = EV_CANCELLED;
                end
                else
                begin
                    ev = EV_CLEARED;
                end
            end
            CMD_LONG:
            begin
                entry_next[wpos] = value_reg;
                value_next       = '0;
                if (wpos != POS_W'(CODE_LENGTH - 1))
                begin
                    pos_next  = POS_W'(wpos + 1'b1);
                    mode_next = commit_mode;
                    ev        = EV_COMMITTED;
                end
                else
                begin
                    pos_next = '0;
                    if (commit_mode == MODE_CHANGE)
                    begin
                        stored_next = entry_next;
                        mode_next   = MODE_ENTER;
                        ev          = EV_SAVED;
                    end
                    else if (entry_next == stored_reg)
                    begin
                        mode_next   = MODE_PROMPT;
                        window_next = cfg.change_window_ms;
                        ev          = EV_UNLOCKED;
                    end
                    else
                    begin
                        mode_next = MODE_ENTER;
                        ev        = EV_DENIED;
                    end
                end
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ENTER;
            pos_reg     <= '0;
            value_reg   <= '0;
            stored_reg  <= code_digits(DEFAULT_CODE_RST);
            window_reg  <= '0;
            was_low_reg <= 1'b0;
            held_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            value_reg   <= value_next;
            stored_reg  <= stored_next;
            window_reg  <= window_next;
            was_low_reg <= was_low_next;
            held_reg    <= held_next;
            done_reg    <= done_next;
        end
    end

    // entry digits are always written before they are compared
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entry_reg <= entry_next;
        end
    end

    assign res.event_res      = ev;
    assign res.lock_mode      = mode_next;
    assign res.digit_position = pos_next;
    assign res.digit_value    = value_next;
endmodule
`default_nettype wire

// ----- hdl/gesture_code_lock_fsm_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gesture_code_lock_fsm_top: four-digit gesture code lock
// input register, combinational lock update, result register
// ----------------------------------------------------------------------------
// Takes one word per clock on the gesture channel (tick, click, double click
// or long press) while no stalled result holds it back, and returns exactly
// one result word for each, in order: the event, the lock mode and the digit
// position and value now being entered. A word passes through the input
// register and then the result register; with the result side ready, one
// word per cycle flows through, since the whole lock update for a word is
// combinational logic between the input register and the state and result
// registers. A stalled result holds in the result register while the input
// register still takes one more word. Configuration writes (hold time, change
// window, factory code) take effect at once and are meant for an idle block.
// No clearing pass after reset: the block is ready straight out of reset.
// ----------------------------------------------------------------------------
module gesture_code_lock_fsm_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    glc_in_if.sink                              gesture,
    glc_out_if.source                           result,
    input  wire logic                           cfg_we,
    input  wire logic [glc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [glc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import glc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    in_take;

    // configuration registers
    glc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // the held word moves on when the result register is free or draining
    assign advance       = item_valid_reg && (!res_valid_reg || result.ready);
    assign gesture.ready = !item_valid_reg || advance;
    assign in_take       = gesture.valid && gesture.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (gesture.ready)
        begin
            item_valid_reg <= gesture.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd       <= cmd_t'(gesture.cmd);
            item_reg.admin_low <= gesture.admin_low;
        end
    end

    // lock state and update logic, state commits on advance
    glc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.event_res      = res_reg.event_res;
    assign result.lock_mode      = res_reg.lock_mode;
    assign result.digit_position = res_reg.digit_position;
    assign result.digit_value    = res_reg.digit_value;

    // an accepted word is held in the input register on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> item_valid_reg)
    else $error("accepted gesture word not held");

    // the digit being entered is always a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.digit_value <= DIGIT_MAX)
    else $error("digit value out of decimal range");

    // an unlock always opens the change prompt
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.event_res == EV_UNLOCKED)
            |-> result.lock_mode == MODE_PROMPT)
    else $error("unlock without change prompt");

    // a saved code or a factory reset leaves fresh entry at the first digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.event_res == EV_SAVED || result.event_res == EV_RESET))
            |-> (result.lock_mode == MODE_ENTER && result.digit_position == '0))
    else $error("save or reset did not restart entry");
endmodule
`default_nettype wire
